FILE: design/mm_pkg.sv
// mm_pkg: shared types, widths and register codes for the matrix multiplier
// used by mm_ctrl, mm_dp and matrix_multiply; depends on nothing else
package mm_pkg;

  // default largest matrix dimension
  localparam int MAX_DIM_DEF = 8;

  // field and register widths
  localparam int ELEM_W    = 16;
  localparam int PROD_W    = 40;
  localparam int COORD_W   = 3;
  localparam int DIM_W     = 4;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B     = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic               wr_en;    // store the incoming element
    logic               wr_b;     // element belongs to B
    logic [COORD_W-1:0] wr_row;
    logic [COORD_W-1:0] wr_col;
    logic               rd_en;    // issue one multiply-accumulate
    logic [COORD_W-1:0] rd_row;
    logic [COORD_W-1:0] rd_col;
    logic [COORD_W-1:0] rd_k;
    logic               first;    // first term of a dot product
    logic               lastk;    // last term of a dot product
    logic               lastall;  // final product element of the run
  } mm_cmd_t;

  // dimension register to (size - 1): zero counts as one, large values clamp
  function automatic logic [COORD_W-1:0] dim_m1(input logic [DIM_W-1:0] v,
                                                input int max_dim);
    logic [COORD_W-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (int'(v) > max_dim) begin
      res = COORD_W'(max_dim - 1);
    end else begin
      res = COORD_W'(v - DIM_W'(1));
    end
    return res;
  endfunction

endpackage

FILE: design/mm_ctrl.sv
// mm_ctrl: load sequencing and multiply-accumulate sequencing state machine
// depends on mm_pkg; drives mm_dp through mm_cmd_t
module mm_ctrl #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        cfg_clear,
  input  logic [mm_pkg::DIM_W-1:0]    rows_a,
  input  logic [mm_pkg::DIM_W-1:0]    inner_size,
  input  logic [mm_pkg::DIM_W-1:0]    cols_b,
  input  logic                        pipe_busy,
  output mm_pkg::mm_cmd_t             cmd
);
  import mm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic               phase_r, phase_nxt;      // 0 loading A, 1 loading B
  logic [COORD_W-1:0] ld_row_r, ld_row_nxt;
  logic [COORD_W-1:0] ld_col_r, ld_col_nxt;
  logic [COORD_W-1:0] cr_r, cr_nxt;
  logic [COORD_W-1:0] cc_r, cc_nxt;
  logic [COORD_W-1:0] ck_r, ck_nxt;

  logic [COORD_W-1:0] nr_m1, nk_m1, nc_m1;
  logic               accept;
  logic               cur_phase;
  logic [COORD_W-1:0] cur_row, cur_col;
  logic               col_end, row_end;

  // effective sizes
  assign nr_m1 = dim_m1(rows_a, MAX_DIM);
  assign nk_m1 = dim_m1(inner_size, MAX_DIM);
  assign nc_m1 = dim_m1(cols_b, MAX_DIM);

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && (state_r == ST_IDLE);

  // a dimension register write drops a partial load before this cycle's element
  assign cur_phase = cfg_clear ? 1'b0 : phase_r;
  assign cur_row   = cfg_clear ? '0 : ld_row_r;
  assign cur_col   = cfg_clear ? '0 : ld_col_r;
  assign col_end   = cur_phase ? (cur_col == nc_m1) : (cur_col == nk_m1);
  assign row_end   = cur_phase ? (cur_row == nk_m1) : (cur_row == nr_m1);

  // next state and counters
  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    ld_row_nxt = ld_row_r;
    ld_col_nxt = ld_col_r;
    cr_nxt     = cr_r;
    cc_nxt     = cc_r;
    ck_nxt     = ck_r;
    unique case (state_r)
      ST_IDLE: begin
        phase_nxt  = cur_phase;
        ld_row_nxt = cur_row;
        ld_col_nxt = cur_col;
        if (accept) begin
          if (col_end) begin
            ld_col_nxt = '0;
            if (row_end) begin
              ld_row_nxt = '0;
              if (cur_phase) begin
                phase_nxt = 1'b0;
                state_nxt = ST_RUN;
                cr_nxt    = '0;
                cc_nxt    = '0;
                ck_nxt    = '0;
              end else begin
                phase_nxt = 1'b1;
              end
            end else begin
              ld_row_nxt = cur_row + COORD_W'(1);
            end
          end else begin
            ld_col_nxt = cur_col + COORD_W'(1);
          end
        end
      end
      ST_RUN: begin
        // one multiply-accumulate issued per cycle, k innermost
        if (ck_r == nk_m1) begin
          ck_nxt = '0;
          if (cc_r == nc_m1) begin
            cc_nxt = '0;
            if (cr_r == nr_m1) begin
              cr_nxt    = '0;
              state_nxt = ST_DRAIN;
            end else begin
              cr_nxt = cr_r + COORD_W'(1);
            end
          end else begin
            cc_nxt = cc_r + COORD_W'(1);
          end
        end else begin
          ck_nxt = ck_r + COORD_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      phase_r  <= 1'b0;
      ld_row_r <= '0;
      ld_col_r <= '0;
      cr_r     <= '0;
      cc_r     <= '0;
      ck_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      ld_row_r <= ld_row_nxt;
      ld_col_r <= ld_col_nxt;
      cr_r     <= cr_nxt;
      cc_r     <= cc_nxt;
      ck_r     <= ck_nxt;
    end
  end

  // commands to the datapath
  always_comb begin
    cmd         = '0;
    cmd.wr_en   = accept;
    cmd.wr_b    = cur_phase;
    cmd.wr_row  = cur_row;
    cmd.wr_col  = cur_col;
    cmd.rd_en   = (state_r == ST_RUN);
    cmd.rd_row  = cr_r;
    cmd.rd_col  = cc_r;
    cmd.rd_k    = ck_r;
    cmd.first   = (ck_r == '0);
    cmd.lastk   = (ck_r == nk_m1);
    cmd.lastall = (cr_r == nr_m1) && (cc_r == nc_m1);
  end

  // computation only starts on the transfer of the last element
  a_run_from_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RUN) ##1 (state_r == ST_RUN) |-> $past(start && !busy))
    else $error("run started without an element transfer");

  // load counters are back at the start of A while computing
  a_load_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (!phase_r && ld_row_r == '0 && ld_col_r == '0))
    else $error("load counters not cleared for the run");

  // a run always ends through the drain state
  a_run_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |=> (state_r == ST_RUN || state_r == ST_DRAIN))
    else $error("run left without draining");

endmodule

FILE: design/mm_dp.sv
// mm_dp: element stores, multiplier pipeline and accumulator with result register
// depends on mm_pkg; commanded by mm_ctrl
module mm_dp #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mm_pkg::mm_cmd_t                     cmd,
  input  logic signed [mm_pkg::ELEM_W-1:0]    in_element,
  output logic                                pipe_busy,
  output logic                                out_valid,
  output logic signed [mm_pkg::PROD_W-1:0]    out_product,
  output logic [mm_pkg::COORD_W-1:0]          out_row,
  output logic [mm_pkg::COORD_W-1:0]          out_col,
  output logic                                out_last
);
  import mm_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int MUL_W  = 2 * ELEM_W;

  logic signed [ELEM_W-1:0] mem_a [DEPTH];
  logic signed [ELEM_W-1:0] mem_b [DEPTH];

  logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;

  // stage 1: store read data
  logic                     s1_v_r;
  logic                     s1_first_r, s1_lastk_r, s1_lastall_r;
  logic [COORD_W-1:0]       s1_row_r, s1_col_r;
  logic signed [ELEM_W-1:0] a_q_r, b_q_r;

  // stage 2: product
  logic                     s2_v_r;
  logic                     s2_first_r, s2_lastk_r, s2_lastall_r;
  logic [COORD_W-1:0]       s2_row_r, s2_col_r;
  logic signed [MUL_W-1:0]  prod_r;

  // accumulator and result register
  logic signed [PROD_W-1:0] acc_r;
  logic signed [PROD_W-1:0] prod_ext, sum;
  logic                     out_valid_r, out_last_r;
  logic signed [PROD_W-1:0] out_product_r;
  logic [COORD_W-1:0]       out_row_r, out_col_r;

  // row-major store address
  function automatic logic [ADDR_W-1:0] addr(input logic [COORD_W-1:0] row,
                                             input logic [COORD_W-1:0] col);
    return ADDR_W'(int'(row) * MAX_DIM + int'(col));
  endfunction

  assign wr_addr   = addr(cmd.wr_row, cmd.wr_col);
  assign rd_addr_a = addr(cmd.rd_row, cmd.rd_k);
  assign rd_addr_b = addr(cmd.rd_k, cmd.rd_col);

  // element stores, one write port and one registered read port each
  always_ff @(posedge clk) begin
    if (cmd.wr_en && !cmd.wr_b) begin
      mem_a[wr_addr] <= in_element;
    end
    if (cmd.rd_en) begin
      a_q_r <= mem_a[rd_addr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en && cmd.wr_b) begin
      mem_b[wr_addr] <= in_element;
    end
    if (cmd.rd_en) begin
      b_q_r <= mem_b[rd_addr_b];
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.rd_en;
      s2_v_r <= s1_v_r;
    end
  end

  // tags follow the operands
  always_ff @(posedge clk) begin
    s1_first_r   <= cmd.first;
    s1_lastk_r   <= cmd.lastk;
    s1_lastall_r <= cmd.lastall;
    s1_row_r     <= cmd.rd_row;
    s1_col_r     <= cmd.rd_col;
    s2_first_r   <= s1_first_r;
    s2_lastk_r   <= s1_lastk_r;
    s2_lastall_r <= s1_lastall_r;
    s2_row_r     <= s1_row_r;
    s2_col_r     <= s1_col_r;
    prod_r       <= a_q_r * b_q_r;
  end

  // accumulate, restarting on the first term of each dot product
  assign prod_ext = PROD_W'(prod_r);
  assign sum      = s2_first_r ? prod_ext : (acc_r + prod_ext);

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      acc_r <= sum;
    end
    if (s2_v_r && s2_lastk_r) begin
      out_product_r <= sum;
      out_row_r     <= s2_row_r;
      out_col_r     <= s2_col_r;
    end
  end

  // result strobe, one cycle per finished element
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      out_valid_r <= s2_v_r && s2_lastk_r;
      out_last_r  <= s2_v_r && s2_lastk_r && s2_lastall_r;
    end
  end

  assign pipe_busy   = s1_v_r || s2_v_r;
  assign out_valid   = out_valid_r;
  assign out_product = out_product_r;
  assign out_row     = out_row_r;
  assign out_col     = out_col_r;
  assign out_last    = out_last_r;

  // a result only follows the final term of a dot product
  a_out_after_lastk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(s2_v_r && s2_lastk_r))
    else $error("result without a completed dot product");

  // last marker only rides on a result
  a_last_with_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_r |-> out_valid_r)
    else $error("last marker without a result");

  // read data only arrives for an issued multiply-accumulate
  a_read_issued: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> $past(cmd.rd_en))
    else $error("operand stage valid without a read");

endmodule

FILE: design/matrix_multiply.sv
// matrix_multiply: top level with dimension registers, controller and datapath
// depends on mm_pkg, mm_ctrl and mm_dp
//
// Elements of A (row-major) and then B (row-major) are loaded one per cycle:
// an element transfers on a clock edge with start high and busy low. The
// transfer of the last B element raises busy; the product is then formed by
// one shared 16x16 multiplier and a 40-bit accumulator, one multiply-
// accumulate per cycle, and busy falls once the multiplier pipeline has drained.
// Each result appears once its dot product is complete, in row-major order,
// on out_product/out_row/out_col for a single cycle with out_valid high and
// out_last set on the final element; there is no back-pressure, so the
// receiver must take each result as it is shown.
// Writing a dimension register while loading drops the partial load.
module matrix_multiply #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [mm_pkg::ELEM_W-1:0]  in_element,
  output logic                              out_valid,
  output logic signed [mm_pkg::PROD_W-1:0]  out_product,
  output logic [mm_pkg::COORD_W-1:0]        out_row,
  output logic [mm_pkg::COORD_W-1:0]        out_col,
  output logic                              out_last,
  input  logic                              cfg_we,
  input  logic [mm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mm_pkg::DIM_W-1:0]          cfg_data
);
  import mm_pkg::*;

  logic [DIM_W-1:0] rows_a_r, inner_size_r, cols_b_r;
  logic             cfg_clear;
  logic             pipe_busy;
  mm_cmd_t          cmd;

  // a write to a known register restarts loading
  assign cfg_clear = cfg_we && ((cfg_index == REG_ROWS_A) ||
                                (cfg_index == REG_INNER_SIZE) ||
                                (cfg_index == REG_COLS_B));

  // dimension registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r     <= DIM_W'(8);
      inner_size_r <= DIM_W'(8);
      cols_b_r     <= DIM_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS_A:     rows_a_r     <= cfg_data;
        REG_INNER_SIZE: inner_size_r <= cfg_data;
        REG_COLS_B:     cols_b_r     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mm_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .cfg_clear  (cfg_clear),
    .rows_a     (rows_a_r),
    .inner_size (inner_size_r),
    .cols_b     (cols_b_r),
    .pipe_busy  (pipe_busy),
    .cmd        (cmd)
  );

  mm_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_element  (in_element),
    .pipe_busy   (pipe_busy),
    .out_valid   (out_valid),
    .out_product (out_product),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_last    (out_last)
  );

endmodule

FILE: verif/tb.sv
// tb: self-checking testbench for matrix_multiply, loads random matrices and checks each
// product element against a behavioural predictor held in the testbench
// depends on mm_pkg and the matrix_multiply design
`timescale 1ns / 1ps

module tb;
  import mm_pkg::*;

  localparam int MAX_DIM     = MAX_DIM_DEF;
  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 12;
  localparam int LAT         = 8;     // margin after the last result before checking busy
  localparam int QUIET_LIMIT = 2000;  // cycles with no transfer at all before giving up
  localparam int ITEMS       = 400;
  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic signed [PROD_W-1:0] value;
    logic [COORD_W-1:0]       row;
    logic [COORD_W-1:0]       col;
    logic                     last;
  } prod_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic signed [ELEM_W-1:0]   in_element = '0;
  logic                       out_valid;
  logic signed [PROD_W-1:0]   out_product;
  logic [COORD_W-1:0]         out_row;
  logic [COORD_W-1:0]         out_col;
  logic                       out_last;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [DIM_W-1:0]           cfg_data = '0;

  // elements waiting for transfer and product elements waiting to arrive
  logic signed [ELEM_W-1:0] elem_q[$];
  prod_t                    product_q[$];
  prod_t                    want;

  // predictor state: dimension registers, both stores and the load position
  logic [DIM_W-1:0]         rows_reg, inner_reg, cols_reg;
  logic signed [ELEM_W-1:0] a_mem [MAX_DIM*MAX_DIM];
  logic signed [ELEM_W-1:0] b_mem [MAX_DIM*MAX_DIM];
  int                       loaded;

  int gap_pct = 0;
  int items_sent = 0;
  int errs = 0;
  int quiet = 0;

  matrix_multiply #(.MAX_DIM(MAX_DIM)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_element (in_element),
    .out_valid  (out_valid),
    .out_product(out_product),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_last   (out_last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  // register value to matrix size: zero counts as one, large values clamp
  function automatic int size_of(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic int run_len();
    return size_of(inner_reg) * (size_of(rows_reg) + size_of(cols_reg));
  endfunction

  // mostly small sizes, some large, now and then a zero or out-of-range value
  function automatic logic [DIM_W-1:0] pick_dim();
    int p;
    p = $urandom_range(99);
    if (p < 65) return DIM_W'($urandom_range(1, 3));
    if (p < 80) return DIM_W'($urandom_range(4, 8));
    if (p < 90) return DIM_W'(MAX_DIM);
    if (p < 94) return '0;
    return DIM_W'($urandom_range(9, 15));
  endfunction

  // store one element; the last element of B yields the whole product
  task automatic load_element(input logic signed [ELEM_W-1:0] e);
    int nr, nk, nc, na, idx, r, c, k;
    longint acc;
    prod_t p;
    nr = size_of(rows_reg);
    nk = size_of(inner_reg);
    nc = size_of(cols_reg);
    na = nr * nk;
    if (loaded < na) begin
      a_mem[(loaded / nk) * MAX_DIM + loaded % nk] = e;
    end else begin
      idx = loaded - na;
      b_mem[(idx / nc) * MAX_DIM + idx % nc] = e;
    end
    loaded++;
    if (loaded == na + nk * nc) begin
      loaded = 0;
      for (r = 0; r < nr; r++) begin
        for (c = 0; c < nc; c++) begin
          acc = 0;
          for (k = 0; k < nk; k++) begin
            acc += longint'(a_mem[r*MAX_DIM + k]) * longint'(b_mem[k*MAX_DIM + c]);
          end
          p.value = PROD_W'(acc);
          p.row   = COORD_W'(r);
          p.col   = COORD_W'(c);
          p.last  = (r == nr - 1) && (c == nc - 1);
          product_q.push_back(p);
        end
      end
    end
  endtask

  task automatic note_mismatch(input string msg);
    errs++;
    if (errs <= 10) $display("mismatch: %s", msg);
  endtask

  // predictor update and result check on every rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      rows_reg  = DIM_RESET;
      inner_reg = DIM_RESET;
      cols_reg  = DIM_RESET;
      loaded    = 0;
      quiet     = 0;
    end else begin
      quiet++;
      // register write: a real register also drops a partial load
      if (cfg_we) begin
        quiet = 0;
        case (cfg_index)
          REG_ROWS_A: begin
            rows_reg = cfg_data;
            loaded = 0;
          end
          REG_INNER_SIZE: begin
            inner_reg = cfg_data;
            loaded = 0;
          end
          REG_COLS_B: begin
            cols_reg = cfg_data;
            loaded = 0;
          end
          default: ;
        endcase
      end
      // element transfer
      if (start && !busy) begin
        quiet = 0;
        load_element(elem_q.pop_front());
      end
      // result transfer against the oldest expectation
      if (out_valid) begin
        quiet = 0;
        if (product_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result %0d at (%0d,%0d) last %0b",
                                  out_product, out_row, out_col, out_last));
        end else begin
          want = product_q.pop_front();
          if (out_product !== want.value || out_row !== want.row ||
              out_col !== want.col || out_last !== want.last) begin
            note_mismatch($sformatf("expected %0d at (%0d,%0d) last %0b, got %0d at (%0d,%0d) last %0b",
                                    want.value, want.row, want.col, want.last,
                                    out_product, out_row, out_col, out_last));
          end
        end
      end
    end
  end

  // element driver, with random gaps in the offer
  always @(negedge clk) begin
    if (elem_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
      start      <= 1'b1;
      in_element <= elem_q[0];
    end else begin
      start      <= 1'b0;
      in_element <= ELEM_W'($urandom);
    end
  end

  // watchdog on cycles with no transfer of any kind
  initial begin
    while (quiet < QUIET_LIMIT) @(posedge clk);
    $display("tb NOT OK");
    $finish;
  end

  task automatic push_elem(input logic signed [ELEM_W-1:0] e);
    elem_q.push_back(e);
    items_sent++;
  endtask

  task automatic push_run(input int n);
    int i, p;
    for (i = 0; i < n; i++) begin
      p = $urandom_range(99);
      if (p < 8) push_elem(16'sh8000);
      else if (p < 16) push_elem(16'sh7FFF);
      else if (p < 20) push_elem('0);
      else push_elem(ELEM_W'($urandom));
    end
  endtask

  // sender holds off until every element is taken and every result is in
  task automatic wait_idle();
    while (elem_q.size() != 0 || product_q.size() != 0) @(negedge clk);
    repeat (LAT) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic wr_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // stimulus
  initial begin
    int run_no, kind, n, k;
    run_no = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one full-size run at the reset dimensions
    push_run(run_len());

    // smallest matrices with zero registers, extreme operands
    wr_cfg(REG_ROWS_A, 4'd0);
    wr_cfg(REG_INNER_SIZE, 4'd1);
    wr_cfg(REG_COLS_B, 4'd0);
    push_elem(16'sh8000);
    push_elem(16'sh8000);
    // write to an unused index in mid-load leaves the load running
    push_elem(16'sh7FFF);
    wr_cfg(REG_UNUSED, 4'hF);
    push_elem(16'sh8000);
    // a real register write in mid-load drops the partial run
    push_elem(16'sh1234);
    wr_cfg(REG_ROWS_A, 4'd2);
    // inner size above the limit clamps, largest possible sum
    wr_cfg(REG_ROWS_A, 4'd1);
    wr_cfg(REG_INNER_SIZE, 4'd9);
    wr_cfg(REG_COLS_B, 4'd1);
    repeat (16) push_elem(16'sh8000);

    // random runs across the idling phases
    while (items_sent < ITEMS) begin
      run_no++;
      case ((run_no / 6) % 4)
        0: gap_pct = 0;
        1: gap_pct = 55;
        2: gap_pct = 0;
        default: gap_pct = 19;
      endcase
      kind = $urandom_range(99);
      if (kind < 55) begin
        wr_cfg(REG_ROWS_A, pick_dim());
        wr_cfg(REG_INNER_SIZE, pick_dim());
        wr_cfg(REG_COLS_B, pick_dim());
      end
      n = run_len();
      k = (n > 1) ? $urandom_range(1, n - 1) : 0;
      if (kind >= 95) begin
        // broken run, dropped by a register write
        push_run(k);
        wr_cfg(CFG_IDX_W'($urandom_range(0, 2)), pick_dim());
      end else if (kind >= 90) begin
        // unused index written in mid-load, run then completed
        push_run(k);
        wr_cfg(REG_UNUSED, DIM_W'($urandom));
        push_run(n - k);
      end else begin
        push_run(n);
        if (kind % 3 == 0) push_run(n);
      end
    end

    // drain and let any stray result show up
    while (elem_q.size() != 0 || product_q.size() != 0) @(negedge clk);
    repeat (3 * LAT) @(negedge clk);
    if (errs == 0 && product_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
